// ===== src/lda_pkg.sv =====
package lda_pkg;

	localparam int MAX_TOPICS = 16;
	localparam int MAX_DOCS   = 1024;
	localparam int MAX_TERMS  = 4096;
	localparam int MAX_TOKENS = 65536;

	localparam int TOPIC_W = $clog2(MAX_TOPICS);
	localparam int DOC_W   = $clog2(MAX_DOCS);
	localparam int TERM_W  = $clog2(MAX_TERMS);
	localparam int TOK_W   = $clog2(MAX_TOKENS);
	localparam int DT_AW   = DOC_W + TOPIC_W;
	localparam int TT_AW   = TOPIC_W + TERM_W;
	localparam int CLR_W   = (DT_AW > TT_AW) ? DT_AW : TT_AW;

	localparam int DT_W = 16;
	localparam int TT_W = 17;

	localparam logic [DT_W-1:0] DT_MAX = '1;
	localparam logic [TT_W-1:0] TT_MAX = '1;

	localparam logic [1:0] REG_ALPHA = 2'd0;
	localparam logic [1:0] REG_BETA  = 2'd1;
	localparam logic [1:0] REG_TOPICS = 2'd2;
	localparam logic [1:0] REG_TERMS = 2'd3;

	localparam logic [31:0] ALPHA_RST  = 32'd6554;
	localparam logic [31:0] BETA_RST   = 32'd6554;
	localparam logic [4:0]  TOPICS_RST = 5'd16;
	localparam logic [12:0] TERMS_RST  = 13'd4096;

	typedef struct packed {
		logic        mode;
		logic [9:0]  doc_index;
		logic [11:0] term_index;
		logic [15:0] token_index;
		logic [15:0] random_value;
	} in_t;

	typedef struct packed {
		logic [3:0] new_topic;
		logic [3:0] old_topic;
	} out_t;

endpackage

// ===== src/lda_div.sv =====
module lda_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [33:0] num,
	input  logic [45:0] den,
	output logic        done,
	output logic [31:0] quot
);

	logic [45:0] rem_q;
	logic [45:0] d_q;
	logic [31:0] n_q;
	logic [31:0] q_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [45:0] d_eff;
	logic        sat;
	logic [46:0] rem2;
	logic        ge;

	assign d_eff = (den == '0) ? 46'd1 : den;
	assign sat   = {28'd0, num} >= {d_eff, 16'd0};
	assign rem2  = {rem_q, n_q[31]};
	assign ge    = rem2 >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (sat) begin
					done_q <= 1'b1;
				end else begin
					run_q <= 1'b1;
					cnt_q <= 5'd31;
				end
			end else if (run_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			d_q   <= d_eff;
			rem_q <= {28'd0, num[33:16]};
			n_q   <= {num[15:0], 16'd0};
			q_q   <= sat ? 32'hFFFF_FFFF : 32'd0;
		end else if (run_q) begin
			n_q <= {n_q[30:0], 1'b0};
			if (ge) begin
				rem_q <= 46'(rem2 - {1'b0, d_q});
				q_q   <= {q_q[30:0], 1'b1};
			end else begin
				rem_q <= rem2[45:0];
				q_q   <= {q_q[30:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = q_q;

endmodule

// ===== src/lda_gibbs_topic_resampler_core.sv =====
// Collapsed Gibbs token step for LDA.
// Channels: an item (req) is taken when start is high and busy is low.
// Its result (new and old topic) shows on result, with done high for
// exactly one cycle; the receiver cannot stall, nothing is held back.
// Registers are written through cfg_we/cfg_index/cfg_data at any edge
// with cfg_we high; write only while the block is idle (not enforced).
// After reset the count memories are swept to zero, one entry a cycle,
// 65536 addresses with busy high; topic totals clear at once in flops.
// Init item: draws a topic from random_value, increments its counts.
// Resample item: decrements the old topic's counts, weighs each topic
// in use and scans for the drawn topic; a saturating divide ends early.
// Each topic costs two memory reads, one bit-serial 32-step divide and
// one 32x32 multiply; the divider is the slowest of these.
// One item is in flight at a time.
module lda_gibbs_topic_resampler_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  lda_pkg::in_t        req,
	output logic                done,
	output lda_pkg::out_t       result,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	localparam logic [3:0] S_CLR    = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_TOKRD  = 4'd2;
	localparam logic [3:0] S_OUTRD  = 4'd3;
	localparam logic [3:0] S_OUTRD2 = 4'd4;
	localparam logic [3:0] S_OUTWR  = 4'd5;
	localparam logic [3:0] S_WRD    = 4'd6;
	localparam logic [3:0] S_WA     = 4'd7;
	localparam logic [3:0] S_WCHK   = 4'd8;
	localparam logic [3:0] S_WDIV   = 4'd9;
	localparam logic [3:0] S_WACC   = 4'd10;
	localparam logic [3:0] S_TGT    = 4'd11;
	localparam logic [3:0] S_SCAN   = 4'd12;
	localparam logic [3:0] S_INCRD  = 4'd13;
	localparam logic [3:0] S_INCWR  = 4'd14;

	localparam int TW  = lda_pkg::TOPIC_W;
	localparam int DTW = lda_pkg::DT_W;
	localparam int TTW = lda_pkg::TT_W;

	logic [3:0]  state_q;
	logic [lda_pkg::CLR_W-1:0] clr_q;

	logic [31:0] alpha_q;
	logic [31:0] beta_q;
	logic [4:0]  topics_q;
	logic [12:0] terms_q;

	logic [lda_pkg::DOC_W-1:0]  doc_q;
	logic [lda_pkg::TERM_W-1:0] term_q;
	logic [lda_pkg::TOK_W-1:0]  tok_q;
	logic [15:0] rnd_q;
	logic [4:0]  ntop_q;
	logic [44:0] bt_q;
	logic [TW-1:0] oldk_q;
	logic [TW-1:0] newk_q;
	logic [TW-1:0] k_q;

	logic [31:0] a_q;
	logic [33:0] b_q;
	logic [45:0] d_q;
	logic [63:0] prod_q;
	logic [35:0] total_q;
	logic [35:0] target_q;
	logic [35:0] cum_q;
	logic [31:0] w_q [lda_pkg::MAX_TOPICS];
	logic [TTW-1:0] tot_q [lda_pkg::MAX_TOPICS];

	logic        done_q;
	lda_pkg::out_t res_q;

	logic [3:0] tok_mem [lda_pkg::MAX_TOKENS];
	logic [DTW-1:0] dt_mem [2**lda_pkg::DT_AW];
	logic [TTW-1:0] tt_mem [2**lda_pkg::TT_AW];
	logic [3:0]     tok_rd;
	logic [DTW-1:0] dt_rd;
	logic [TTW-1:0] tt_rd;

	logic [TW-1:0] sel_k;
	logic [lda_pkg::DT_AW-1:0] dt_a;
	logic [lda_pkg::TT_AW-1:0] tt_a;
	logic dt_we;
	logic tok_we;
	logic [DTW-1:0] dt_wd;
	logic [TTW-1:0] tt_wd;
	logic [TTW-1:0] tot_sel;

	logic [4:0]  ntop_c;
	logic [12:0] nterms_c;
	logic [20:0] init_p;
	logic [32:0] a_sum;
	logic [35:0] cum_n;
	logic [51:0] tgt_p;
	logic [47:0] w_sh;
	logic [31:0] w_new;

	logic div_start;
	logic div_done;
	logic [31:0] div_q;

	assign ntop_c = (topics_q < 5'd2) ? 5'd2 :
		(topics_q > 5'(lda_pkg::MAX_TOPICS)) ? 5'(lda_pkg::MAX_TOPICS) : topics_q;
	assign nterms_c = (terms_q == '0) ? 13'd1 :
		(terms_q > 13'(lda_pkg::MAX_TERMS)) ? 13'(lda_pkg::MAX_TERMS) : terms_q;
	assign init_p = {5'd0, req.random_value} * {16'd0, ntop_c};

	always_comb begin
		unique case (state_q)
			S_OUTRD2, S_OUTWR: sel_k = oldk_q;
			S_INCRD, S_INCWR:  sel_k = newk_q;
			default:           sel_k = k_q;
		endcase
	end

	assign tot_sel = tot_q[sel_k];
	assign dt_a = (state_q == S_CLR) ? clr_q[lda_pkg::DT_AW-1:0] : {doc_q, sel_k};
	assign tt_a = (state_q == S_CLR) ? clr_q[lda_pkg::TT_AW-1:0] : {sel_k, term_q};
	assign dt_we = (state_q == S_CLR) || (state_q == S_OUTWR) || (state_q == S_INCWR);
	assign tok_we = state_q == S_INCWR;

	always_comb begin
		unique case (state_q)
			S_OUTWR: begin
				dt_wd = (dt_rd == '0) ? '0 : DTW'(dt_rd - 1'b1);
				tt_wd = (tt_rd == '0) ? '0 : TTW'(tt_rd - 1'b1);
			end
			S_INCWR: begin
				dt_wd = (dt_rd == lda_pkg::DT_MAX) ? dt_rd : DTW'(dt_rd + 1'b1);
				tt_wd = (tt_rd == lda_pkg::TT_MAX) ? tt_rd : TTW'(tt_rd + 1'b1);
			end
			default: begin
				dt_wd = '0;
				tt_wd = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (dt_we) begin
			dt_mem[dt_a] <= dt_wd;
			tt_mem[tt_a] <= tt_wd;
		end
		dt_rd <= dt_mem[dt_a];
		tt_rd <= tt_mem[tt_a];
	end

	always_ff @(posedge clk) begin
		if (tok_we) begin
			tok_mem[tok_q] <= newk_q;
		end
		tok_rd <= tok_mem[tok_q];
	end

	assign a_sum = {1'b0, alpha_q} + {1'b0, dt_rd, 16'd0};
	assign w_sh  = prod_q[63:16];
	assign w_new = (w_sh[47:32] != '0) ? 32'hFFFF_FFFF : w_sh[31:0];
	assign cum_n = cum_q + {4'd0, w_q[k_q]};
	assign tgt_p = {16'd0, total_q} * {36'd0, rnd_q};
	assign div_start = state_q == S_WCHK;

	lda_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (b_q),
		.den    (d_q),
		.done   (div_done),
		.quot   (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q  <= lda_pkg::ALPHA_RST;
			beta_q   <= lda_pkg::BETA_RST;
			topics_q <= lda_pkg::TOPICS_RST;
			terms_q  <= lda_pkg::TERMS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lda_pkg::REG_ALPHA:  alpha_q  <= cfg_data;
				lda_pkg::REG_BETA:   beta_q   <= cfg_data;
				lda_pkg::REG_TOPICS: topics_q <= cfg_data[4:0];
				lda_pkg::REG_TERMS:  terms_q  <= cfg_data[12:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			done_q  <= 1'b0;
			for (int i = 0; i < lda_pkg::MAX_TOPICS; i++) begin
				tot_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= req.mode ? S_TOKRD : S_INCRD;
					end
				end
				S_TOKRD:  state_q <= S_OUTRD;
				S_OUTRD:  state_q <= S_OUTRD2;
				S_OUTRD2: state_q <= S_OUTWR;
				S_OUTWR: begin
					tot_q[sel_k] <= (tot_sel == '0) ? '0 : TTW'(tot_sel - 1'b1);
					state_q <= S_WRD;
				end
				S_WRD:  state_q <= S_WA;
				S_WA:   state_q <= S_WCHK;
				S_WCHK: state_q <= S_WDIV;
				S_WDIV: begin
					if (div_done) begin
						state_q <= S_WACC;
					end
				end
				S_WACC: begin
					state_q <= ({1'b0, k_q} == 5'(ntop_q - 5'd1)) ? S_TGT : S_WRD;
				end
				S_TGT: state_q <= S_SCAN;
				S_SCAN: begin
					if (cum_n > target_q || {1'b0, k_q} == 5'(ntop_q - 5'd1)) begin
						state_q <= S_INCRD;
					end
				end
				S_INCRD: state_q <= S_INCWR;
				S_INCWR: begin
					tot_q[sel_k] <= (tot_sel == lda_pkg::TT_MAX) ? tot_sel : TTW'(tot_sel + 1'b1);
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				doc_q  <= req.doc_index;
				term_q <= req.term_index;
				tok_q  <= req.token_index;
				rnd_q  <= req.random_value;
				ntop_q <= ntop_c;
				bt_q   <= {13'd0, beta_q} * {32'd0, nterms_c};
				oldk_q <= '0;
				newk_q <= init_p[16 +: TW];
				k_q    <= '0;
			end
			S_OUTRD: begin
				oldk_q  <= tok_rd;
				total_q <= '0;
			end
			S_WA: begin
				a_q <= a_sum[32] ? 32'hFFFF_FFFF : a_sum[31:0];
				b_q <= {2'd0, beta_q} + {1'b0, tt_rd, 16'd0};
				d_q <= {13'd0, tot_sel, 16'd0} + {1'b0, bt_q};
			end
			S_WDIV: begin
				if (div_done) begin
					prod_q <= {32'd0, a_q} * {32'd0, div_q};
				end
			end
			S_WACC: begin
				w_q[k_q] <= w_new;
				total_q  <= total_q + {4'd0, w_new};
				k_q      <= TW'(k_q + 1'b1);
			end
			S_TGT: begin
				target_q <= tgt_p[51:16];
				cum_q    <= '0;
				k_q      <= '0;
			end
			S_SCAN: begin
				cum_q  <= cum_n;
				newk_q <= k_q;
				k_q    <= TW'(k_q + 1'b1);
			end
			S_INCWR: begin
				res_q.new_topic <= newk_q;
				res_q.old_topic <= oldk_q;
			end
			default: begin
			end
		endcase
	end

	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = res_q;

endmodule
